// ===== rtl/ttca_pkg.sv =====
// ttca_pkg: shared types, constants and the rule digit decoder for the
// three-state totalistic ring. No dependencies.
package ttca_pkg;

    localparam int CELL_COUNT_DEF = 64;
    localparam int MAX_CELLS      = 64;
    localparam int STATE_W        = 2;
    localparam int TALLY_W        = 16;
    localparam int RULE_W         = 12;
    localparam int SUM_CODES      = 7;
    localparam int DIGITS_W       = 2 * SUM_CODES;
    localparam int INDEX_W        = 6;
    localparam int TOTAL_W        = 8;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = RULE_W;

    localparam logic [RULE_W-1:0] RULE_MOD = 12'd2187;
    localparam logic [RULE_W-1:0] POW3 [0:SUM_CODES-1] =
        '{12'd1, 12'd3, 12'd9, 12'd27, 12'd81, 12'd243, 12'd729};

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_EVOLVE = 2'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_RULE_NUMBER   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE = 1'b1;

    localparam logic [STATE_W-1:0] INIT_VALUE_RESET = 2'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] cell_index;
    } in_beat_t;

    typedef struct packed {
        logic [63:0]        states_low;
        logic [63:0]        states_high;
        logic [TOTAL_W-1:0] state_total;
        logic [STATE_W-1:0] selected_state;
        logic [TALLY_W-1:0] selected_count;
    } out_beat_t;

    typedef struct packed {
        logic                init;
        logic                evolve;
        logic [STATE_W-1:0]  init_state;
        logic [DIGITS_W-1:0] digits;
    } cell_ctrl_t;

    // base-3 digits of the rule, digit k in bits [2k+1:2k]
    function automatic logic [DIGITS_W-1:0] rule_digits(input logic [RULE_W-1:0] value);
        logic [RULE_W-1:0]   r;
        logic [DIGITS_W-1:0] d;
        r = value;
        d = '0;
        if (r >= RULE_MOD) begin
            r = r - RULE_MOD;
        end
        for (int k = SUM_CODES - 1; k >= 0; k--) begin
            if (r >= (POW3[k] << 1)) begin
                d[2*k +: 2] = 2'd2;
                r = r - (POW3[k] << 1);
            end else if (r >= POW3[k]) begin
                d[2*k +: 2] = 2'd1;
                r = r - POW3[k];
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/totalistic_ternary_ca_ring.sv =====
// totalistic_ternary_ca_ring: top level, ring of cells, control and output register.
// Depends on ttca_pkg, ttca_cell and ttca_total.
//
//  port group | dir | role
//  s_*        | in  | command beat: operation, cell_index
//  m_*        | out | result beat: packed states, total, selected cell
//  cfg_*      | in  | register write: rule_number, initial_value
//
// each beat runs in order: accept (all cells update in parallel), group sums
// of the adder tree, then final sum into the output register.
// a new beat is taken once the previous one has reached the output register.
// a stalled result holds the ring from advancing further.
// reset clears all cells and tallies, rule 0, initial value 1.
module totalistic_ternary_ca_ring #(
    parameter int CELL_COUNT = ttca_pkg::CELL_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ttca_pkg::in_beat_t                s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ttca_pkg::out_beat_t               m_payload,
    input  logic                              cfg_we,
    input  logic [ttca_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ttca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SUM  = 2'd1;
    localparam logic [1:0] PH_OUT  = 2'd2;

    logic [1:0]                        phase_reg, phase_next;
    logic [ttca_pkg::DIGITS_W-1:0]     digits_reg;
    logic [ttca_pkg::STATE_W-1:0]      init_value_reg;
    logic [1:0]                        op_reg;
    logic [ttca_pkg::INDEX_W-1:0]      idx_reg;
    logic                              m_valid_reg;
    ttca_pkg::out_beat_t               out_reg;
    logic                              accept, load_out;
    ttca_pkg::cell_ctrl_t              ctrl;

    logic [ttca_pkg::STATE_W-1:0]      cell_state [CELL_COUNT];
    logic [ttca_pkg::TALLY_W-1:0]      cell_tally [CELL_COUNT];
    logic [ttca_pkg::STATE_W-1:0]      state_pad  [ttca_pkg::MAX_CELLS];
    logic [ttca_pkg::TALLY_W-1:0]      tally_pad  [ttca_pkg::MAX_CELLS];
    logic [2*ttca_pkg::MAX_CELLS-1:0]  states_flat;
    logic [ttca_pkg::TOTAL_W-1:0]      total;
    logic                              is_read;

    assign s_ready = (phase_reg == PH_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        ctrl.init       = accept && (s_payload.operation == ttca_pkg::OP_INIT);
        ctrl.evolve     = accept && (s_payload.operation == ttca_pkg::OP_EVOLVE);
        ctrl.init_state = (init_value_reg == 2'd3) ? 2'd2 : init_value_reg;
        ctrl.digits     = digits_reg;
    end

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        localparam int LEFT  = (i == 0) ? CELL_COUNT - 1 : i - 1;
        localparam int RIGHT = (i == CELL_COUNT - 1) ? 0 : i + 1;
        ttca_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .is_mid      ((i == CELL_COUNT / 2) ? 1'b1 : 1'b0),
            .left_state  (cell_state[LEFT]),
            .right_state (cell_state[RIGHT]),
            .state       (cell_state[i]),
            .tally       (cell_tally[i])
        );
    end

    for (genvar i = 0; i < ttca_pkg::MAX_CELLS; i++) begin : g_pad
        if (i < CELL_COUNT) begin : g_live
            assign state_pad[i] = cell_state[i];
            assign tally_pad[i] = cell_tally[i];
        end else begin : g_none
            assign state_pad[i] = '0;
            assign tally_pad[i] = '0;
        end
        assign states_flat[2*i +: 2] = state_pad[i];
    end

    ttca_total u_total (
        .aclk        (aclk),
        .group_load  (phase_reg == PH_SUM),
        .states_flat (states_flat),
        .total       (total)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg     <= '0;
            init_value_reg <= ttca_pkg::INIT_VALUE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ttca_pkg::REG_RULE_NUMBER:   digits_reg     <= ttca_pkg::rule_digits(cfg_data);
                ttca_pkg::REG_INITIAL_VALUE: init_value_reg <= cfg_data[ttca_pkg::STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    assign load_out = (phase_reg == PH_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        case (phase_reg)
            PH_IDLE: phase_next = accept ? PH_SUM : PH_IDLE;
            PH_SUM:  phase_next = PH_OUT;
            PH_OUT:  phase_next = load_out ? PH_IDLE : PH_OUT;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_payload.operation;
            idx_reg <= s_payload.cell_index;
        end
    end

    assign is_read = (op_reg != ttca_pkg::OP_INIT) && (op_reg != ttca_pkg::OP_EVOLVE);

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg.states_low     <= states_flat[63:0];
            out_reg.states_high    <= states_flat[127:64];
            out_reg.state_total    <= total;
            out_reg.selected_state <= is_read ? state_pad[idx_reg] : '0;
            out_reg.selected_count <= is_read ? tally_pad[idx_reg] : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    a_accept_starts_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> phase_reg == PH_SUM)
        else $error("accepted beat did not enter sum phase");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OUT && m_valid_reg && !m_ready |=> phase_reg == PH_OUT)
        else $error("pending result overwritten during stall");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.state_total <= ttca_pkg::TOTAL_W'(2 * CELL_COUNT))
        else $error("state total out of range");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(phase_reg) == PH_OUT)
        else $error("result raised outside output phase");

endmodule

// ===== rtl/ttca_cell.sv =====
// ttca_cell: one ring cell holding its state and saturating tally.
// Depends on ttca_pkg.
module ttca_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ttca_pkg::cell_ctrl_t          ctrl,
    input  logic                          is_mid,
    input  logic [ttca_pkg::STATE_W-1:0]  left_state,
    input  logic [ttca_pkg::STATE_W-1:0]  right_state,
    output logic [ttca_pkg::STATE_W-1:0]  state,
    output logic [ttca_pkg::TALLY_W-1:0]  tally
);

    logic [ttca_pkg::STATE_W-1:0] state_reg, state_next, rule_out;
    logic [ttca_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic [2:0]                   nbr_sum;
    logic [ttca_pkg::TALLY_W:0]   tally_sum;

    assign nbr_sum = 3'(left_state) + 3'(state_reg) + 3'(right_state);

    always_comb begin
        case (nbr_sum)
            3'd0:    rule_out = ctrl.digits[1:0];
            3'd1:    rule_out = ctrl.digits[3:2];
            3'd2:    rule_out = ctrl.digits[5:4];
            3'd3:    rule_out = ctrl.digits[7:6];
            3'd4:    rule_out = ctrl.digits[9:8];
            3'd5:    rule_out = ctrl.digits[11:10];
            3'd6:    rule_out = ctrl.digits[13:12];
            default: rule_out = '0;
        endcase
    end

    assign tally_sum = {1'b0, tally_reg} + (ttca_pkg::TALLY_W+1)'(rule_out);

    always_comb begin
        state_next = state_reg;
        tally_next = tally_reg;
        if (ctrl.init) begin
            state_next = is_mid ? ctrl.init_state : '0;
            tally_next = is_mid ? ttca_pkg::TALLY_W'(ctrl.init_state) : '0;
        end else if (ctrl.evolve) begin
            state_next = rule_out;
            tally_next = tally_sum[ttca_pkg::TALLY_W] ? '1 : tally_sum[ttca_pkg::TALLY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            tally_reg <= '0;
        end else begin
            state_reg <= state_next;
            tally_reg <= tally_next;
        end
    end

    assign state = state_reg;
    assign tally = tally_reg;

endmodule

// ===== rtl/ttca_total.sv =====
// ttca_total: two-level adder tree over the packed cell states, group sums registered.
// Depends on ttca_pkg.
module ttca_total (
    input  logic                                   aclk,
    input  logic                                   group_load,
    input  logic [2*ttca_pkg::MAX_CELLS-1:0]       states_flat,
    output logic [ttca_pkg::TOTAL_W-1:0]           total
);

    localparam int GROUP  = 8;
    localparam int GROUPS = ttca_pkg::MAX_CELLS / GROUP;

    logic [4:0] group_reg  [GROUPS];
    logic [4:0] group_next [GROUPS];

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            group_next[g] = '0;
            for (int c = 0; c < GROUP; c++) begin
                group_next[g] = group_next[g] + 5'(states_flat[2*(g*GROUP+c) +: 2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (group_load) begin
            for (int g = 0; g < GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + ttca_pkg::TOTAL_W'(group_reg[g]);
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for totalistic_ternary_ca_ring, predicting
// every result beat from a local copy of the ring. Depends on ttca_pkg and the RTL.
module testbench;

    localparam int RING_CELLS = ttca_pkg::CELL_COUNT_DEF;
    localparam int MID_CELL   = RING_CELLS / 2;
    localparam int QUIET_MAX  = 2000;
    localparam int PRINT_MAX  = 40;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_READ_ALT = 2'd3;
    localparam logic [ttca_pkg::TALLY_W:0] TALLY_TOP = 17'h0FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ttca_pkg::in_beat_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ttca_pkg::out_beat_t m_payload;
    logic cfg_we = 1'b0;
    logic [ttca_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ttca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    totalistic_ternary_ca_ring uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the ring and its registers
    logic [ttca_pkg::STATE_W-1:0] ring_state [RING_CELLS];
    logic [ttca_pkg::TALLY_W-1:0] ring_tally [RING_CELLS];
    logic [ttca_pkg::RULE_W-1:0]  rule_reg = '0;
    logic [1:0]                   seed_reg = ttca_pkg::INIT_VALUE_RESET;

    ttca_pkg::in_beat_t  cmd_q [$];
    ttca_pkg::out_beat_t ring_results_q [$];
    ttca_pkg::out_beat_t want, got;
    int cmds_queued = 0;
    int cmds_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit cmd_taken = 1'b0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    initial begin
        for (int i = 0; i < RING_CELLS; i++) begin
            ring_state[i] = '0;
            ring_tally[i] = '0;
        end
    end

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [1:0] rule_digit(int sum);
        int unsigned r;
        r = rule_reg;
        repeat (sum) r = r / 3;
        return 2'(r % 3);
    endfunction

    function automatic ttca_pkg::out_beat_t ring_step(ttca_pkg::in_beat_t cmd);
        ttca_pkg::out_beat_t res;
        logic [ttca_pkg::STATE_W-1:0] nxt [RING_CELLS];
        logic [ttca_pkg::TALLY_W:0] t;
        logic [1:0] seed;
        int lf, rt, sum;
        res = '0;
        case (cmd.operation)
            ttca_pkg::OP_INIT: begin
                seed = (seed_reg == 2'd3) ? 2'd2 : seed_reg;
                for (int i = 0; i < RING_CELLS; i++) begin
                    ring_state[i] = '0;
                    ring_tally[i] = '0;
                end
                ring_state[MID_CELL] = seed;
                ring_tally[MID_CELL] = ttca_pkg::TALLY_W'(seed);
            end
            ttca_pkg::OP_EVOLVE: begin
                for (int i = 0; i < RING_CELLS; i++) begin
                    lf = (i == 0) ? RING_CELLS - 1 : i - 1;
                    rt = (i == RING_CELLS - 1) ? 0 : i + 1;
                    sum = int'(ring_state[lf]) + int'(ring_state[i]) + int'(ring_state[rt]);
                    nxt[i] = rule_digit(sum);
                end
                for (int i = 0; i < RING_CELLS; i++) begin
                    t = {1'b0, ring_tally[i]} + (ttca_pkg::TALLY_W + 1)'(nxt[i]);
                    ring_state[i] = nxt[i];
                    ring_tally[i] = (t > TALLY_TOP) ? TALLY_TOP[ttca_pkg::TALLY_W-1:0]
                                                    : t[ttca_pkg::TALLY_W-1:0];
                end
            end
            default: begin
                if (int'(cmd.cell_index) < RING_CELLS) begin
                    res.selected_state = ring_state[cmd.cell_index];
                    res.selected_count = ring_tally[cmd.cell_index];
                end
            end
        endcase
        for (int i = 0; i < RING_CELLS; i++) begin
            res.state_total += ttca_pkg::TOTAL_W'(ring_state[i]);
            if (i < 32) res.states_low[2*i +: 2] = ring_state[i];
            else res.states_high[2*(i-32) +: 2] = ring_state[i];
        end
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] g, logic [63:0] w);
        errors++;
        if (errors <= PRINT_MAX)
            $display("mismatch at result %0d: %s got %h expected %h", results_seen, field, g, w);
    endtask

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || cmd_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                s_payload <= cmd_q.pop_front();
                s_valid <= 1'b1;
                gap_left = gaps_on ? idle_len() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
        cmd_taken = 1'b0;
    end

    // result receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 4) == 0) stall_left = idle_len();
        end
    end

    // beat monitor, prediction, checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                ring_results_q.push_back(ring_step(s_payload));
                cmds_taken++;
                cmd_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                got = m_payload;
                if (ring_results_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(got.state_total), '0);
                end else begin
                    want = ring_results_q.pop_front();
                    if (got.states_low !== want.states_low)
                        report_mismatch("states_low", got.states_low, want.states_low);
                    if (got.states_high !== want.states_high)
                        report_mismatch("states_high", got.states_high, want.states_high);
                    if (got.state_total !== want.state_total)
                        report_mismatch("state_total", 64'(got.state_total),
                                        64'(want.state_total));
                    if (got.selected_state !== want.selected_state)
                        report_mismatch("selected_state", 64'(got.selected_state),
                                        64'(want.selected_state));
                    if (got.selected_count !== want.selected_count)
                        report_mismatch("selected_count", 64'(got.selected_count),
                                        64'(want.selected_count));
                end
                results_seen++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [ttca_pkg::INDEX_W-1:0] idx);
        ttca_pkg::in_beat_t c;
        c.operation = op;
        c.cell_index = idx;
        cmd_q.push_back(c);
        cmds_queued++;
    endtask

    task automatic drain();
        while (cmds_taken != cmds_queued || ring_results_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [ttca_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ttca_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == ttca_pkg::REG_RULE_NUMBER) rule_reg = data;
        else seed_reg = data[1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return ttca_pkg::OP_INIT;
        if (r < 66) return ttca_pkg::OP_EVOLVE;
        if (r < 84) return OP_READ;
        return OP_READ_ALT;
    endfunction

    task automatic random_run(int n);
        push_cmd(ttca_pkg::OP_INIT, ttca_pkg::INDEX_W'($urandom));
        for (int i = 0; i < n; i++) begin
            push_cmd(rand_op(), ttca_pkg::INDEX_W'($urandom_range(0, 63)));
            if (i % 32 == 31) begin
                if ($urandom_range(0, 2) == 0) drain();
                else while (cmd_q.size() > 8) @(negedge aclk);
            end
        end
        drain();
    endtask

    initial begin
        logic [ttca_pkg::RULE_W-1:0] rule_pick;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // reset state: rule 0, initial value 1
        push_cmd(OP_READ, 6'd0);
        push_cmd(OP_READ_ALT, 6'd63);
        push_cmd(ttca_pkg::OP_INIT, 6'd63);
        push_cmd(OP_READ, 6'd32);
        push_cmd(OP_READ, 6'd31);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd0);
        push_cmd(OP_READ_ALT, 6'd32);
        drain();

        // all digits 2, initial value 3 acts as 2
        write_reg(ttca_pkg::REG_RULE_NUMBER, 12'd2186);
        write_reg(ttca_pkg::REG_INITIAL_VALUE, {10'h3ff, 2'd3});
        push_cmd(ttca_pkg::OP_INIT, 6'd21);
        push_cmd(OP_READ, 6'd32);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd42);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd0);
        push_cmd(OP_READ, 6'd63);
        push_cmd(OP_READ_ALT, 6'd0);
        drain();

        // rule above the top, initial value 0 and then 2
        write_reg(ttca_pkg::REG_RULE_NUMBER, 12'd4095);
        write_reg(ttca_pkg::REG_INITIAL_VALUE, {10'h155, 2'd0});
        push_cmd(ttca_pkg::OP_INIT, 6'd32);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd1);
        push_cmd(OP_READ, 6'd32);
        drain();
        write_reg(ttca_pkg::REG_INITIAL_VALUE, {10'h2aa, 2'd2});
        push_cmd(ttca_pkg::OP_INIT, 6'd0);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd63);
        push_cmd(ttca_pkg::OP_EVOLVE, 6'd63);
        push_cmd(OP_READ, 6'd33);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: rule_pick = (p == 0) ? 12'd0 : ttca_pkg::RULE_W'($urandom_range(0, 2186));
                1: rule_pick = (p == 1) ? 12'd2186 : ttca_pkg::RULE_W'($urandom_range(0, 2186));
                2: rule_pick = (p == 2) ? 12'd4095
                                        : ttca_pkg::RULE_W'($urandom_range(2187, 4095));
                default: rule_pick = ttca_pkg::RULE_W'($urandom_range(0, 2186));
            endcase
            gaps_on = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            stalls_on = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            write_reg(ttca_pkg::REG_RULE_NUMBER, rule_pick);
            write_reg(ttca_pkg::REG_INITIAL_VALUE, {10'($urandom), 2'(p % 4)});
            random_run(135);
        end

        // back-to-back evolve run under the all-2 rule
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        write_reg(ttca_pkg::REG_RULE_NUMBER, 12'd2186);
        write_reg(ttca_pkg::REG_INITIAL_VALUE, 12'd1);
        push_cmd(ttca_pkg::OP_INIT, 6'd0);
        for (int i = 0; i < 40; i++) begin
            push_cmd(ttca_pkg::OP_EVOLVE, ttca_pkg::INDEX_W'($urandom));
            if (i % 10 == 9) push_cmd(OP_READ, ttca_pkg::INDEX_W'($urandom));
        end
        push_cmd(OP_READ, 6'd0);
        push_cmd(OP_READ, 6'd32);
        push_cmd(OP_READ_ALT, 6'd63);
        drain();

        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (20) @(negedge aclk);
        if (errors == 0 && ring_results_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ttca_pkg.sv
rtl/ttca_cell.sv
rtl/ttca_total.sv
rtl/totalistic_ternary_ca_ring.sv
sim/testbench.sv
